// File: src/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg
// Shared constants and the result layout for the console line editor.
// ----------------------------------------------------------------------------
package cel_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 32;

    localparam logic OP_RECV = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] KEY_DUMP = 8'h10;
    localparam logic [7:0] KEY_KILL = 8'h15;
    localparam logic [7:0] KEY_BS   = 8'h08;
    localparam logic [7:0] KEY_DEL  = 8'h7f;
    localparam logic [7:0] KEY_EOF  = 8'h04;
    localparam logic [7:0] KEY_LF   = 8'h0a;
    localparam logic [7:0] KEY_CR   = 8'h0d;

    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_CHAR  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;
    localparam logic [1:0] ECHO_EOF   = 2'd3;

    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_BYTE  = 2'd1;
    localparam logic [1:0] RD_EMPTY = 2'd2;
    localparam logic [1:0] RD_EOF   = 2'd3;

    typedef struct packed {
        logic       pad;
        logic       line_end;
        logic [7:0] read_byte;
        logic [1:0] read_status;
        logic       dump_request;
        logic       line_committed;
        logic [7:0] erase_count;
        logic [7:0] echo_char;
        logic [1:0] echo_kind;
    } cel_result_t;

endpackage

// File: src/cel_ram.sv
// ----------------------------------------------------------------------------
// cel_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/console_line_editor.sv
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical terminal line editor over a ring of DEPTH bytes.
// ----------------------------------------------------------------------------
// Input beats carry a receive item (s_tuser = 0, a typed key) or a read item
// (s_tuser = 1, pop one committed byte). Every input beat yields exactly one
// output beat on m_* holding the echo code, erase count, commit and dump
// flags, and the read status with the popped byte.
// A receive beat, or a read beat that finds nothing committed, shows its
// result in the cycle after acceptance. A read beat with committed data goes
// through ST_FETCH to take the line store RAM's registered read data first.
// Receive beats: one per cycle unless stalled; ST_FETCH takes no new beat.
// The line store itself holds no reset; the read, commit and edit indices
// clear at reset, so only written entries are ever read.
// While the output beat waits on m_tready, s_tready stays low; the held
// beat and all indices stay unchanged until it is taken.
// ----------------------------------------------------------------------------
module console_line_editor #(
    parameter int DEPTH = cel_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [7:0] key, [8] first_of_call, [15:9] zero
    input  logic [cel_pkg::S_DATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic [cel_pkg::S_USER_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] echo_kind, [9:2] echo_char, [17:10] erase_count,
    // [18] line_committed, [19] dump_request, [21:20] read_status,
    // [29:22] read_byte, [30] line_end, [31] zero
    output logic [cel_pkg::M_DATA_W-1:0] m_tdata
);

    import cel_pkg::*;

    localparam int SPAN = 2 * DEPTH;
    localparam int IW   = $clog2(SPAN);
    localparam int AW   = $clog2(DEPTH);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic          state_reg, state_next;
    logic [IW-1:0] read_reg, read_next;
    logic [IW-1:0] commit_reg, commit_next;
    logic [IW-1:0] edit_reg, edit_next;
    logic          first_reg, first_next;
    logic          m_tvalid_reg, m_tvalid_next;
    cel_result_t   out_reg, out_next;

    logic          accept;
    logic          op;
    logic [7:0]    key;
    logic          first_of_call;
    logic [7:0]    stored_char;

    logic [IW:0]   fill_diff;
    logic [IW-1:0] fill;
    logic [IW:0]   kill_diff;
    logic [IW-1:0] kill_count;
    logic [IW-1:0] edit_inc;
    logic [IW-1:0] edit_dec;
    logic [IW-1:0] read_inc;
    logic [AW-1:0] edit_slot;
    logic [AW-1:0] read_slot;

    logic          wr_en;
    logic [7:0]    rd_data;

    assign op            = s_tuser[0];
    assign key           = s_tdata[7:0];
    assign first_of_call = s_tdata[8];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign fill_diff  = {1'b0, edit_reg} - {1'b0, read_reg};
    assign fill       = (edit_reg >= read_reg) ? fill_diff[IW-1:0]
                                               : IW'(fill_diff + (IW+1)'(SPAN));
    assign kill_diff  = {1'b0, edit_reg} - {1'b0, commit_reg};
    assign kill_count = (edit_reg >= commit_reg) ? kill_diff[IW-1:0]
                                                 : IW'(kill_diff + (IW+1)'(SPAN));

    assign edit_inc = (edit_reg == IW'(SPAN - 1)) ? '0 : edit_reg + 1'b1;
    assign edit_dec = (edit_reg == '0) ? IW'(SPAN - 1) : edit_reg - 1'b1;
    assign read_inc = (read_reg == IW'(SPAN - 1)) ? '0 : read_reg + 1'b1;

    assign edit_slot = AW'((edit_reg >= IW'(DEPTH)) ? edit_reg - IW'(DEPTH) : edit_reg);
    assign read_slot = AW'((read_reg >= IW'(DEPTH)) ? read_reg - IW'(DEPTH) : read_reg);

    assign stored_char = (key == KEY_CR) ? KEY_LF : key;

    cel_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (edit_slot),
        .wr_data (stored_char),
        .rd_addr (read_slot),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        read_next     = read_reg;
        commit_next   = commit_reg;
        edit_next     = edit_reg;
        first_next    = first_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        wr_en         = 1'b0;

        if (accept) begin
            out_next      = '0;
            m_tvalid_next = 1'b1;
            if (op == OP_RECV) begin
                case (key)
                    KEY_DUMP: begin
                        out_next.dump_request = 1'b1;
                    end
                    KEY_KILL: begin
                        if (kill_count != '0) begin
                            edit_next            = commit_reg;
                            out_next.echo_kind   = ECHO_ERASE;
                            out_next.erase_count = (32'(kill_count) > 32'd255) ? 8'd255
                                                                            : 8'(kill_count);
                        end
                    end
                    KEY_BS, KEY_DEL: begin
                        if (edit_reg != commit_reg) begin
                            edit_next            = edit_dec;
                            out_next.echo_kind   = ECHO_ERASE;
                            out_next.erase_count = 8'd1;
                        end
                    end
                    default: begin
                        if (key != 8'd0 && fill < IW'(DEPTH) && key != KEY_LF) begin
                            wr_en     = 1'b1;
                            edit_next = edit_inc;
                            if (stored_char == KEY_EOF) begin
                                out_next.echo_kind = ECHO_EOF;
                            end else begin
                                out_next.echo_kind = ECHO_CHAR;
                                out_next.echo_char = stored_char;
                            end
                            if (stored_char == KEY_LF || stored_char == KEY_EOF
                                || fill == IW'(DEPTH - 1)) begin
                                commit_next             = edit_inc;
                                out_next.line_committed = 1'b1;
                            end
                        end
                    end
                endcase
            end else begin
                if (read_reg == commit_reg) begin
                    out_next.read_status = RD_EMPTY;
                end else begin
                    m_tvalid_next = 1'b0;
                    first_next    = first_of_call;
                    state_next    = ST_FETCH;
                end
            end
        end else if (state_reg == ST_FETCH) begin
            out_next      = '0;
            m_tvalid_next = 1'b1;
            state_next    = ST_IDLE;
            if (rd_data == KEY_EOF) begin
                out_next.read_status = RD_EOF;
                if (first_reg) begin
                    read_next = read_inc;
                end
            end else begin
                read_next          = read_inc;
                out_next.read_status = RD_BYTE;
                out_next.read_byte = rd_data;
                out_next.line_end  = (rd_data == KEY_LF);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            read_reg     <= '0;
            commit_reg   <= '0;
            edit_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            read_reg     <= read_next;
            commit_reg   <= commit_next;
            edit_reg     <= edit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        first_reg <= first_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

// File: src/cel_checker.sv
// ----------------------------------------------------------------------------
// cel_checker
// Port-level checks for the console line editor, bound to the top level.
// ----------------------------------------------------------------------------
module cel_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [cel_pkg::M_DATA_W-1:0] m_tdata
);

    import cel_pkg::*;

    cel_result_t res;
    assign res = m_tdata;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output beat is stalled");

    a_read_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.read_status != RD_NONE |->
            res.echo_kind == ECHO_NONE && !res.line_committed && !res.dump_request)
        else $error("read beat carries edit results");

    a_echo_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.echo_kind != ECHO_CHAR |-> res.echo_char == 8'd0)
        else $error("echo_char set without a character echo");

endmodule

bind console_line_editor cel_checker u_cel_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb_console_line_editor.sv
// ----------------------------------------------------------------------------
// tb_console_line_editor
// Self-checking bench for the console line editor. A directed opening covers
// the control keys, empty-line erases, ignored keys, CR to LF, end-of-file
// reads with and without a fresh reader call, and line kill. Random traffic
// follows: typed lines with edits and terminators, a ring flood up to full,
// read bursts, and noise beats. A local model of the ring and its three
// indices predicts every result beat, which is checked field by field.
// Four phases vary source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_console_line_editor;
    import cel_pkg::*;

    localparam int RING        = DEPTH_DEFAULT;
    localparam int IDX_W       = $clog2(2 * RING);
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_KEYS  = 160;

    typedef struct packed {
        logic       op;
        logic [7:0] key;
        logic       first;
    } keystroke_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    keystroke_t  keystroke_q[$];
    cel_result_t response_q[$];
    int          keys_queued   = 0;
    int          keys_taken    = 0;
    int          errors        = 0;
    int          cycles        = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    logic [7:0]       line_ring [RING];
    logic [IDX_W-1:0] rd_idx = '0;
    logic [IDX_W-1:0] cm_idx = '0;
    logic [IDX_W-1:0] ed_idx = '0;

    console_line_editor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic cel_result_t console_response(logic op, logic [7:0] key,
                                                     logic first);
        cel_result_t      r;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] used;
        logic [7:0]       c;
        int               n;
        logic             stop;
        r = '0;
        if (op == OP_RECV) begin
            if (key == KEY_DUMP) begin
                r.dump_request = 1'b1;
            end else if (key == KEY_KILL) begin
                n = 0;
                stop = 1'b0;
                while (!stop) begin
                    prev = ed_idx - 1'b1;
                    if (ed_idx == cm_idx || line_ring[prev[IDX_W-2:0]] == KEY_LF) begin
                        stop = 1'b1;
                    end else begin
                        ed_idx = prev;
                        n++;
                    end
                end
                if (n != 0) begin
                    r.echo_kind   = ECHO_ERASE;
                    r.erase_count = (n > 255) ? 8'd255 : n[7:0];
                end
            end else if (key == KEY_BS || key == KEY_DEL) begin
                if (ed_idx != cm_idx) begin
                    ed_idx        = ed_idx - 1'b1;
                    r.echo_kind   = ECHO_ERASE;
                    r.erase_count = 8'd1;
                end
            end else begin
                used = ed_idx - rd_idx;
                if (key != '0 && used < RING && key != KEY_LF) begin
                    c = (key == KEY_CR) ? KEY_LF : key;
                    line_ring[ed_idx[IDX_W-2:0]] = c;
                    ed_idx = ed_idx + 1'b1;
                    if (c == KEY_EOF) begin
                        r.echo_kind = ECHO_EOF;
                    end else begin
                        r.echo_kind = ECHO_CHAR;
                        r.echo_char = c;
                    end
                    used = ed_idx - rd_idx;
                    if (c == KEY_LF || c == KEY_EOF || used == RING) begin
                        cm_idx           = ed_idx;
                        r.line_committed = 1'b1;
                    end
                end
            end
        end else begin
            if (rd_idx == cm_idx) begin
                r.read_status = RD_EMPTY;
            end else begin
                c = line_ring[rd_idx[IDX_W-2:0]];
                if (c == KEY_EOF) begin
                    r.read_status = RD_EOF;
                    if (first) begin
                        rd_idx = rd_idx + 1'b1;
                    end
                end else begin
                    rd_idx        = rd_idx + 1'b1;
                    r.read_status = RD_BYTE;
                    r.read_byte   = c;
                    r.line_end    = (c == KEY_LF);
                end
            end
        end
        return r;
    endfunction

    task automatic push_key(logic op, logic [7:0] key, logic first);
        keystroke_t k;
        k.op    = op;
        k.key   = key;
        k.first = first;
        keystroke_q.push_back(k);
        keys_queued++;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_random_traffic(int target, bit flood);
        int         start;
        int         len;
        int         pick;
        int         j;
        logic [7:0] k;
        start = keys_queued;
        if (flood) begin
            len = $urandom_range(128, 134);
            for (j = 0; j < len; j++) begin
                push_key(OP_RECV, 8'($urandom_range(32, 126)), 1'($urandom_range(0, 1)));
            end
            push_key(OP_RECV, KEY_BS, 1'b0);
            push_key(OP_RECV, KEY_KILL, 1'b1);
        end
        while (keys_queued - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = $urandom_range(0, 12);
                for (j = 0; j < len; j++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80) begin
                        k = 8'($urandom_range(32, 254));
                    end else if (pick < 88) begin
                        k = pick[0] ? KEY_BS : KEY_DEL;
                    end else if (pick < 93) begin
                        k = KEY_KILL;
                    end else begin
                        k = 8'($urandom_range(0, 255));
                    end
                    push_key(OP_RECV, k, 1'($urandom_range(0, 1)));
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    push_key(OP_RECV, KEY_CR, 1'($urandom_range(0, 1)));
                end else if (pick < 85) begin
                    push_key(OP_RECV, KEY_EOF, 1'($urandom_range(0, 1)));
                end
                len = len + $urandom_range(0, 3);
                for (j = 0; j < len; j++) begin
                    push_key(OP_READ, 8'($urandom_range(0, 255)),
                             (j == 0) || ($urandom_range(0, 3) == 0));
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    push_key(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_key(OP_READ, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    always @(posedge aclk) begin : driver
        keystroke_t k;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                response_q.push_back(console_response(s_tuser[0], s_tdata[7:0],
                                                      s_tdata[8]));
                keys_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (keystroke_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    k = keystroke_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, k.first, k.key};
                    s_tuser  <= k.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        cel_result_t got;
        cel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (response_q.size() == 0) begin
                $display("%0t unexpected result beat: expected none actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = response_q.pop_front();
                check_field("echo_kind", want.echo_kind, got.echo_kind);
                check_field("echo_char", want.echo_char, got.echo_char);
                check_field("erase_count", want.erase_count, got.erase_count);
                check_field("line_committed", want.line_committed, got.line_committed);
                check_field("dump_request", want.dump_request, got.dump_request);
                check_field("read_status", want.read_status, got.read_status);
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("line_end", want.line_end, got.line_end);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d result beats outstanding", $time,
                     response_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        push_key(OP_RECV, KEY_DUMP, 1'b0);
        push_key(OP_RECV, KEY_KILL, 1'b1);
        push_key(OP_RECV, KEY_BS, 1'b0);
        push_key(OP_RECV, KEY_DEL, 1'b1);
        push_key(OP_RECV, 8'h00, 1'b0);
        push_key(OP_RECV, KEY_LF, 1'b1);
        push_key(OP_READ, 8'hff, 1'b1);
        push_key(OP_RECV, 8'h61, 1'b0);
        push_key(OP_RECV, 8'hff, 1'b1);
        push_key(OP_RECV, 8'h01, 1'b0);
        push_key(OP_RECV, KEY_BS, 1'b0);
        push_key(OP_RECV, 8'h62, 1'b0);
        push_key(OP_RECV, KEY_DEL, 1'b0);
        push_key(OP_RECV, 8'h80, 1'b0);
        push_key(OP_RECV, KEY_KILL, 1'b0);
        push_key(OP_RECV, 8'hfe, 1'b1);
        push_key(OP_RECV, KEY_CR, 1'b0);
        push_key(OP_READ, 8'h00, 1'b1);
        push_key(OP_READ, 8'h55, 1'b0);
        push_key(OP_READ, 8'haa, 1'b0);
        push_key(OP_RECV, KEY_EOF, 1'b0);
        push_key(OP_READ, 8'h00, 1'b0);
        push_key(OP_READ, 8'h00, 1'b0);
        push_key(OP_READ, 8'h00, 1'b1);
        push_key(OP_READ, 8'h00, 1'b1);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 69;
                end
                default: begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase
            add_random_traffic(PHASE_KEYS, (ph == 1) || (ph == 3));
            while (!(keys_taken == keys_queued && response_q.size() == 0)) begin
                @(posedge aclk);
            end
        end

        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
